### hdl/thac_pkg.sv
// Shared types, widths and constants for the thermistor ADC to Celsius block.
// No dependencies; every other file imports this package.
`default_nettype none
package thac_pkg;

   // converter resolution; the code port itself is fixed at 12 bits
   localparam int ADC_BITS   = 12;
   localparam int CODE_IN_W  = 12;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int RES_W      = 20;
   localparam int BETA_W     = 14;
   localparam int T0_W       = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_SERIES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_T0      = 2'd3;

   localparam logic [RES_W-1:0]         RS_RESET   = 20'd10000;
   localparam logic [RES_W-1:0]         R0_RESET   = 20'd10000;
   localparam logic [BETA_W-1:0]        BETA_RESET = 14'd3950;
   localparam logic signed [T0_W-1:0]   T0_RESET   = 15'sd2500;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   // log2 unit: 20-bit operand, Q5.16 result with a 5-bit integer part
   localparam int LOG_IN_W   = 20;
   localparam int LOG_N_W    = 5;
   localparam int LOG_FRAC_W = 16;
   localparam int LOG_W      = LOG_N_W + LOG_FRAC_W;
   localparam int LOG_STAGES = LOG_FRAC_W + 1;

   localparam int L2_W    = 24;
   localparam int LNP_W   = 56;
   localparam int T0C_W   = 17;
   localparam int P1_W    = 41;
   localparam int P2_W    = 30;
   localparam int DEN_W   = 42;
   localparam int NUM_W   = 53;
   localparam int REM_W   = 58;
   localparam int QUO_W   = 16;
   localparam int TEMP_W  = 16;

   localparam logic [31:0]               LN2_Q32      = 32'd2977044472;
   localparam logic signed [T0C_W-1:0]   KELVIN_CENTI = 17'sd27315;
   localparam logic signed [TEMP_W-1:0]  TEMP_MAX     = 16'sd32767;

   typedef struct packed {
      logic [ADC_BITS-1:0] code;
      logic                zero;
   } item_type;

   typedef struct packed {
      logic [RES_W-1:0]        rs;
      logic [RES_W-1:0]        r0;
      logic [BETA_W-1:0]       beta;
      logic signed [T0_W-1:0]  t0;
   } cfg_type;

endpackage
`default_nettype wire

### hdl/thac_front.sv
// Front end: takes ADC requests, masks and classifies the code, and queues it.
// Depends on thac_pkg.
`default_nettype none
module thac_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [thac_pkg::CODE_IN_W-1:0]  req_adc_code,
   output logic                                 q_valid,
   output thac_pkg::item_type                   q_item,
   input  wire logic                            q_pop
);
   import thac_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = 2;

   item_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ff, rd_ff;
   logic [PTR_W:0]       cnt_ff;
   logic [ADC_BITS+CODE_IN_W-1:0] code_ext;
   item_type             item_in;
   logic                 push, pop;

   assign code_ext     = {{ADC_BITS{1'b0}}, req_adc_code};
   assign item_in.code = code_ext[ADC_BITS-1:0];
   assign item_in.zero = (code_ext[ADC_BITS-1:0] == '0);

   assign req_stall = (cnt_ff == (PTR_W+1)'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= item_in;
   end

endmodule
`default_nettype wire

### hdl/thac_log2.sv
// Pipelined base-2 logarithm, Q5.16 out: one normalize stage, then one
// squaring step per fraction bit. Depends on thac_pkg.
`default_nettype none
module thac_log2 (
   input  wire logic                           clock,
   input  wire logic                           adv,
   input  wire logic [thac_pkg::LOG_IN_W-1:0]  x,
   output logic [thac_pkg::LOG_W-1:0]          y
);
   import thac_pkg::*;

   logic [31:0]            m_ff    [LOG_STAGES];
   logic [LOG_N_W-1:0]     n_ff    [LOG_STAGES];
   logic [LOG_FRAC_W-1:0]  frac_ff [LOG_STAGES];
   logic [LOG_IN_W-1:0]    x1;
   logic [LOG_N_W-1:0]     n_in;

   // treat zero as one
   assign x1 = (x == '0) ? LOG_IN_W'(1) : x;

   always_comb begin
      n_in = '0;
      for (int i = 0; i < LOG_IN_W; i++) begin
         if (x1[i]) n_in = LOG_N_W'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff[0]    <= 32'(x1) << (LOG_N_W'(31) - n_in);
         n_ff[0]    <= n_in;
         frac_ff[0] <= '0;
      end
   end

   for (genvar s = 1; s < LOG_STAGES; s++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] t;
      assign sq = 64'(m_ff[s-1]) * 64'(m_ff[s-1]);
      assign t  = sq[63:31];
      always_ff @(posedge clock) begin
         if (adv) begin
            m_ff[s]    <= t[32] ? t[32:1] : t[31:0];
            n_ff[s]    <= n_ff[s-1];
            frac_ff[s] <= {frac_ff[s-1][LOG_FRAC_W-2:0], t[32]};
         end
      end
   end

   assign y = {n_ff[LOG_STAGES-1], frac_ff[LOG_STAGES-1]};

endmodule
`default_nettype wire

### hdl/thac_back.sv
// Back end: log lanes, ln scaling, beta equation and a pipelined divider,
// ending in the response register. Depends on thac_pkg and thac_log2.
`default_nettype none
module thac_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire thac_pkg::cfg_type               cfg,
   input  wire logic                            q_valid,
   input  wire thac_pkg::item_type              q_item,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [thac_pkg::TEMP_W-1:0]   rsp_temp_centi_c,
   output logic [1:0]                           rsp_status
);
   import thac_pkg::*;

   logic adv;
   logic out_vld_ff;
   logic signed [TEMP_W-1:0] out_temp_ff;
   logic [1:0]               out_status_ff;

   // the whole pipe moves together unless the response register is held
   assign adv   = !out_vld_ff || !rsp_stall;
   assign q_pop = adv && q_valid;

   // ---------------- log lanes
   logic [ADC_BITS:0]   span;
   logic [LOG_W-1:0]    la, lb, lc, ld;
   assign span = {1'b1, {ADC_BITS{1'b0}}} - {1'b0, q_item.code};

   thac_log2 u_log_rs   (.clock, .adv, .x(cfg.rs), .y(la));
   thac_log2 u_log_code (.clock, .adv, .x(LOG_IN_W'(q_item.code)), .y(lb));
   thac_log2 u_log_span (.clock, .adv, .x(LOG_IN_W'(span)), .y(lc));
   thac_log2 u_log_r0   (.clock, .adv, .x(cfg.r0), .y(ld));

   logic v_ff [LOG_STAGES];
   logic z_ff [LOG_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOG_STAGES; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= q_valid;
         for (int i = 1; i < LOG_STAGES; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z_ff[0] <= q_item.zero;
         for (int i = 1; i < LOG_STAGES; i++) z_ff[i] <= z_ff[i-1];
      end
   end

   // ---------------- ln, beta equation
   logic                     va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff;
   logic                     za_ff, zb_ff, zc_ff, zd_ff, ze_ff, zf_ff, zg_ff;
   logic signed [L2_W-1:0]   l2_ff;
   logic [LNP_W-1:0]         lnp_ff;
   logic                     neg_ff;
   logic signed [L2_W-1:0]   ln_ff;
   logic signed [P1_W-1:0]   p1_ff;
   logic [P2_W-1:0]          p2_ff;
   logic signed [DEN_W-1:0]  den_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [REM_W-1:0]         nf_ff, denf_ff;
   logic                     satf_ff;
   logic [REM_W-1:0]         remg_ff, deng_ff;
   logic                     satg_ff;

   logic signed [L2_W-1:0]   l2_in;
   logic [L2_W-1:0]          mag;
   logic [LNP_W-1:0]         rnd;
   logic signed [L2_W-1:0]   ln_in;
   logic signed [T0C_W-1:0]  t0c;
   logic signed [P1_W-1:0]   p1_in;
   logic [20:0]              kb;
   logic [36:0]              num_sc;
   logic signed [DEN_W-1:0]  den_in;
   logic [REM_W-1:0]         nf_in;
   logic                     satg_in;

   assign l2_in = $signed(L2_W'(la)) + $signed(L2_W'(lb))
                - $signed(L2_W'(lc)) - $signed(L2_W'(ld));
   assign mag   = l2_ff[L2_W-1] ? L2_W'(-l2_ff) : L2_W'(l2_ff);
   assign rnd   = lnp_ff + (LNP_W'(1) << 31);
   assign ln_in = neg_ff ? -$signed(rnd[55:32]) : $signed(rnd[55:32]);
   assign t0c   = T0C_W'(cfg.t0) + KELVIN_CENTI;
   assign p1_in = P1_W'(ln_ff) * P1_W'(t0c);
   assign kb    = 21'(cfg.beta) * 21'd100;
   assign num_sc = 37'(p2_ff) * 37'd100;
   assign den_in = $signed(p1_ff) + $signed({5'b0, kb, 16'b0});
   // den is positive here when used; half of it rounds the quotient
   assign nf_in  = REM_W'(num_ff) + REM_W'(den_ff[DEN_W-1:1]);
   assign satg_in = satf_ff || (nf_ff >= (denf_ff << QUO_W));

   always_ff @(posedge clock) begin
      if (reset) begin
         {va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff} <= '0;
      end else if (adv) begin
         va_ff <= v_ff[LOG_STAGES-1];
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         vg_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         za_ff   <= z_ff[LOG_STAGES-1];
         zb_ff   <= za_ff;
         zc_ff   <= zb_ff;
         zd_ff   <= zc_ff;
         ze_ff   <= zd_ff;
         zf_ff   <= ze_ff;
         zg_ff   <= zf_ff;
         l2_ff   <= l2_in;
         lnp_ff  <= LNP_W'(mag) * LNP_W'(LN2_Q32);
         neg_ff  <= l2_ff[L2_W-1];
         ln_ff   <= ln_in;
         p1_ff   <= p1_in;
         p2_ff   <= P2_W'(cfg.beta) * P2_W'(t0c);
         den_ff  <= den_in;
         num_ff  <= {num_sc, 16'b0};
         nf_ff   <= nf_in;
         denf_ff <= REM_W'(den_ff[DEN_W-2:0]);
         satf_ff <= (den_ff <= 0);
         remg_ff <= nf_ff;
         deng_ff <= denf_ff;
         satg_ff <= satg_in;
      end
   end

   // ---------------- divider, one quotient bit per stage
   logic                dv_ff   [QUO_W];
   logic                dz_ff   [QUO_W];
   logic                ds_ff   [QUO_W];
   logic [REM_W-1:0]    drem_ff [QUO_W];
   logic [REM_W-1:0]    dden_ff [QUO_W];
   logic [QUO_W-1:0]    dq_ff   [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      localparam int K = QUO_W - 1 - j;
      logic             v_src, z_src, s_src;
      logic [REM_W-1:0] rem_src, den_src, dsh;
      logic [QUO_W-1:0] q_src;
      logic             take;
      if (j == 0) begin : g_first
         assign v_src   = vg_ff;
         assign z_src   = zg_ff;
         assign s_src   = satg_ff;
         assign rem_src = remg_ff;
         assign den_src = deng_ff;
         assign q_src   = '0;
      end else begin : g_next
         assign v_src   = dv_ff[j-1];
         assign z_src   = dz_ff[j-1];
         assign s_src   = ds_ff[j-1];
         assign rem_src = drem_ff[j-1];
         assign den_src = dden_ff[j-1];
         assign q_src   = dq_ff[j-1];
      end
      assign dsh  = den_src << K;
      assign take = (rem_src >= dsh);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dz_ff[j]   <= z_src;
            ds_ff[j]   <= s_src;
            dden_ff[j] <= den_src;
            drem_ff[j] <= take ? rem_src - dsh : rem_src;
            dq_ff[j]   <= q_src | (QUO_W'(take) << K);
         end
      end
   end

   // ---------------- result and response register
   logic signed [QUO_W+1:0]  tk;
   logic signed [TEMP_W-1:0] temp_in;
   logic [1:0]               status_in;

   assign tk = $signed({2'b0, dq_ff[QUO_W-1]}) - (QUO_W+2)'(KELVIN_CENTI);

   always_comb begin
      temp_in   = TEMP_W'(tk);
      status_in = STATUS_OK;
      if (dz_ff[QUO_W-1]) begin
         temp_in   = '0;
         status_in = STATUS_ZERO;
      end else if (ds_ff[QUO_W-1] || (tk > (QUO_W+2)'(TEMP_MAX))) begin
         temp_in   = TEMP_MAX;
         status_in = STATUS_SAT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= dv_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_temp_ff   <= temp_in;
         out_status_ff <= status_in;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_temp_centi_c = out_temp_ff;
   assign rsp_status       = out_status_ff;

endmodule
`default_nettype wire

### hdl/thermistor_adc_to_celsius_top.sv
// Top level: register file, front end queue and back end datapath.
// Depends on thac_pkg, thac_front and thac_back.
//
//   channel  ports                               direction  handshake
//   req      req_adc_code                        in         req_valid / req_stall
//   rsp      rsp_temp_centi_c, rsp_status        out        rsp_valid / rsp_stall
//   csr      csr_index, csr_wdata                in         csr_valid / csr_ready
//
// One request per cycle is taken in steady state while no response is stalled;
// each request passes the queue slot, 17 log stages, seven ln and beta-equation
// stages and 16 quotient stages on its way to the response register.
// A four-entry queue holds requests while the response is stalled. Reset is
// synchronous and clears the queue, all valid flags and the registers to their
// defaults. rsp_stall freezes the whole datapath while a response waits.
`default_nettype none
module thermistor_adc_to_celsius_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [thac_pkg::CODE_IN_W-1:0]   req_adc_code,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [thac_pkg::TEMP_W-1:0]    rsp_temp_centi_c,
   output logic [1:0]                            rsp_status,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [thac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [thac_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import thac_pkg::*;

   cfg_type  cfg_ff;
   logic     q_valid, q_pop;
   item_type q_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rs   <= RS_RESET;
         cfg_ff.r0   <= R0_RESET;
         cfg_ff.beta <= BETA_RESET;
         cfg_ff.t0   <= T0_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SERIES:  cfg_ff.rs   <= csr_wdata[RES_W-1:0];
            CSR_NOMINAL: cfg_ff.r0   <= csr_wdata[RES_W-1:0];
            CSR_BETA:    cfg_ff.beta <= csr_wdata[BETA_W-1:0];
            CSR_T0:      cfg_ff.t0   <= $signed(csr_wdata[T0_W-1:0]);
            default: ;
         endcase
      end
   end

   thac_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_adc_code,
      .q_valid, .q_item, .q_pop
   );

   thac_back u_back (
      .clock, .reset, .cfg(cfg_ff), .q_valid, .q_item, .q_pop,
      .rsp_valid, .rsp_stall, .rsp_temp_centi_c, .rsp_status
   );

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ZERO |-> rsp_temp_centi_c == '0)
      else $error("zero-code response carries a nonzero temperature");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_SAT |-> rsp_temp_centi_c == TEMP_MAX)
      else $error("saturated response not at full scale");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_ZERO
                 || rsp_status == STATUS_SAT)
      else $error("undefined status code");

   a_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_temp_centi_c >= -16'sd27315)
      else $error("temperature below absolute zero");

endmodule
`default_nettype wire
